// ----- rtl/binary_to_decimal_ascii_assert.svh -----
// Assertion macros used by the converter RTL.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define B2DA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/b2da_pkg.sv -----
// Types and constants of the binary to decimal ASCII converter.
`timescale 1ns / 1ps
package b2da_pkg;
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  localparam char_t  ASCII_ZERO = 6'd48;
  localparam char_t  ASCII_NINE = 6'd57;
  localparam digit_t DABBLE_MIN = 4'd5;
  localparam digit_t DABBLE_ADD = 4'd3;
endpackage

// ----- rtl/b2da_in_if.sv -----
// Valid/ready channel that carries one binary value.
`timescale 1ns / 1ps
interface b2da_in_if;
  import b2da_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/b2da_out_if.sv -----
// Valid/ready channel that carries one ASCII digit and its last flag.
`timescale 1ns / 1ps
interface b2da_out_if;
  import b2da_pkg::*;
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- rtl/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter: bit-serial double dabble, digit-serial output.
//
//   channel   dir  payload              request moves
//   in_chan   in   value[63:0]          one number to convert
//   out_chan  out  char_code[5:0], last one ASCII digit, MSD first
//
// An item is taken only in idle; it then runs double dabble, one bit per
// cycle, then digit shifting, one digit per cycle while the output is free
// (leading zeros are shifted out without a request).
// A stalled output holds the digit shifter (leading zeros still shift out); the
// next item may be taken while the final digit still waits in the output register.
// Reset (synchronous, active low) clears the state and the output valid.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_assert.svh"
module binary_to_decimal_ascii #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input logic       clk,
  input logic       rst_n,
  b2da_in_if.sink   in_chan,
  b2da_out_if.source out_chan
);
  import b2da_pkg::*;

  localparam int BCD_W  = MAX_DIGITS * DIGIT_W;
  localparam int STEP_W = $clog2(VALUE_BITS);
  localparam int REM_W  = $clog2(MAX_DIGITS + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_BITS - 1);
  localparam logic [REM_W-1:0]  REM_FULL  = REM_W'(MAX_DIGITS);
  localparam logic [REM_W-1:0]  REM_ONE   = REM_W'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic                  skip_r, skip_nxt;
  logic [BCD_W-1:0]      digits_r, digits_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic                  out_valid_r, out_valid_nxt;
  char_t                 out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [BCD_W-1:0]      adjusted;
  digit_t                top_digit;
  logic                  in_acc;
  logic                  out_free;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign top_digit = digits_r[BCD_W-1 -: DIGIT_W];

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.char_code = out_char_r;
  assign out_chan.last      = out_last_r;

  // Add 3 to every digit of 5 or more ahead of the shift.
  always_comb begin
    adjusted = digits_r;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (digits_r[k*DIGIT_W +: DIGIT_W] >= DABBLE_MIN) begin
        adjusted[k*DIGIT_W +: DIGIT_W] = digits_r[k*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rem_nxt       = rem_r;
    skip_nxt      = skip_r;
    digits_nxt    = digits_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          bin_nxt    = in_chan.value[VALUE_BITS-1:0];
          digits_nxt = '0;
          step_nxt   = '0;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        // Drop the carry out of the top digit.
        digits_nxt = {adjusted[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt    = bin_r << 1;
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          rem_nxt   = REM_FULL;
          skip_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (skip_r && (top_digit == '0) && (rem_r != REM_ONE)) begin
          // Leading zero: shift it out without a request.
          digits_nxt = digits_r << DIGIT_W;
          rem_nxt    = rem_r - REM_ONE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + CHAR_W'(top_digit);
          out_last_nxt  = (rem_r == REM_ONE);
          skip_nxt      = 1'b0;
          digits_nxt    = digits_r << DIGIT_W;
          rem_nxt       = rem_r - REM_ONE;
          if (rem_r == REM_ONE) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      rem_r       <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rem_r       <= rem_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    bin_r      <= bin_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  `B2DA_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, in_acc, (state_r == ST_CONV) && (step_r == '0), "accepted item did not start conversion")
  `B2DA_ASSERT_NOW(a_emit_has_digits, clk, rst_n, state_r == ST_EMIT, rem_r != '0, "emission with no digits left")
  `B2DA_ASSERT_NOW(a_mid_digit_in_emit, clk, rst_n, out_valid_r && !out_last_r, state_r == ST_EMIT, "non-final digit pending outside emission")
  `B2DA_ASSERT_NOW(a_char_is_digit, clk, rst_n, out_valid_r, (out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_NINE), "output is not a decimal digit")
endmodule
